// ----- hdl/nalsplit_pkg.sv -----
`timescale 1ns / 1ps

package nalsplit_pkg;

    localparam int LEN_WIDTH   = 24;
    localparam int MIN_NAL_LEN = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_WIDTH-1:0] POS_MAX = {LEN_WIDTH{1'b1}};

    localparam logic [7:0] START_CODE_LAST = 8'h01;

    localparam logic [4:0] H264_IDR = 5'd5;
    localparam logic [4:0] H264_SPS = 5'd7;
    localparam logic [4:0] H264_PPS = 5'd8;
    localparam logic [5:0] H265_IRAP_FIRST = 6'd19;
    localparam logic [5:0] H265_IRAP_LAST  = 6'd21;
    localparam logic [5:0] H265_VPS = 6'd32;
    localparam logic [5:0] H265_SPS = 6'd33;

    localparam logic [LEN_WIDTH-1:0] SHORT_AU_LAST_POS = LEN_WIDTH'(5);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       au_last;
    } nalsplit_in_t;

    typedef struct packed {
        logic                 nal_valid;
        logic [LEN_WIDTH-1:0] nal_offset;
        logic [LEN_WIDTH-1:0] nal_length;
        logic [7:0]           nal_header;
        logic [4:0]           type_h264;
        logic [5:0]           type_h265;
        logic                 au_end;
        logic                 au_keyframe;
    } nalsplit_out_t;

    // Classified byte handed from the front end to the back end.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic               au_last;
        logic               start;
        logic [LEN_WIDTH-1:0] pos;
        logic [LEN_WIDTH-1:0] pos_inc;
        logic [LEN_WIDTH:0] end_pos;
        logic               long_au;
    } nalsplit_evt_t;

    function automatic logic [4:0] h264_type(input logic [7:0] hdr);
        h264_type = hdr[4:0];
    endfunction

    function automatic logic [5:0] h265_type(input logic [7:0] hdr);
        h265_type = hdr[6:1];
    endfunction

    function automatic logic is_key_header(input logic [7:0] hdr);
        logic [4:0] t4;
        logic [5:0] t5;
        t4 = h264_type(hdr);
        t5 = h265_type(hdr);
        is_key_header = (t4 == H264_IDR) || (t4 == H264_SPS) || (t4 == H264_PPS)
            || (t5 == H265_VPS) || (t5 == H265_SPS)
            || ((t5 >= H265_IRAP_FIRST) && (t5 <= H265_IRAP_LAST));
    endfunction

endpackage

// ----- hdl/annexb_nal_splitter_keyframe_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Payload          Handshake
// s_        in         nalsplit_in_t    s_valid / s_ready
// m_        out        nalsplit_out_t   m_valid / m_ready
//
// One byte is taken per cycle while s_ready is high; each byte's classified event is written into
// the queue, and its result is registered in the output register when the back end pops it.
// The front end classifies start codes and tracks the byte position, and a two-entry
// queue feeds the back end, which tracks the open NAL unit and holds the output register.
// Reset is synchronous and active low and clears all control state.
// While a result waits with m_ready low, the queue fills up to its two entries and s_ready drops.

module annexb_nal_splitter_keyframe_unit import nalsplit_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  nalsplit_in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output nalsplit_out_t m_data
);

    nalsplit_evt_t front_evt;
    nalsplit_evt_t back_evt;
    logic          queue_full;
    logic          queue_not_empty;
    logic          queue_pop;

    assign s_ready = !queue_full;

    nalsplit_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_data  (s_data),
        .accept   (s_ready),
        .evt      (front_evt)
    );

    nalsplit_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_evt),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_data  (back_evt)
    );

    nalsplit_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_valid (queue_not_empty),
        .evt       (back_evt),
        .evt_pop   (queue_pop),
        .out_valid (m_valid),
        .out_data  (m_data),
        .out_ready (m_ready)
    );

endmodule

// ----- hdl/nalsplit_front.sv -----
`timescale 1ns / 1ps

module nalsplit_front import nalsplit_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  nalsplit_in_t  in_data,
    input  logic          accept,
    output nalsplit_evt_t evt
);

    logic [23:0]          hist_reg;
    logic [23:0]          hist_next;
    logic [LEN_WIDTH-1:0] pos_reg;
    logic [LEN_WIDTH-1:0] pos_next;
    logic [LEN_WIDTH-1:0] pos_inc;
    logic                 start;
    logic                 four;

    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + LEN_WIDTH'(1);
    assign start   = (pos_reg >= LEN_WIDTH'(2)) && (hist_reg[15:0] == 16'h0000)
                     && (in_data.data_byte == START_CODE_LAST);
    assign four    = start && (pos_reg >= LEN_WIDTH'(3)) && (hist_reg[23:16] == 8'h00);

    always_comb begin
        evt.data_byte = in_data.data_byte;
        evt.au_last   = in_data.au_last;
        evt.start     = start;
        evt.pos       = pos_reg;
        evt.pos_inc   = pos_inc;
        evt.long_au   = pos_reg >= SHORT_AU_LAST_POS;
        if (start && four) begin
            evt.end_pos = {1'b0, pos_reg} - (LEN_WIDTH+1)'(3);
        end else if (start) begin
            evt.end_pos = {1'b0, pos_reg} - (LEN_WIDTH+1)'(2);
        end else begin
            evt.end_pos = {1'b0, pos_reg} + (LEN_WIDTH+1)'(1);
        end
    end

    always_comb begin
        hist_next = hist_reg;
        pos_next  = pos_reg;
        if (in_valid && accept) begin
            if (in_data.au_last) begin
                hist_next = '0;
                pos_next  = '0;
            end else begin
                hist_next = {hist_reg[15:0], in_data.data_byte};
                pos_next  = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
            pos_reg  <= '0;
        end else begin
            hist_reg <= hist_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ----- hdl/nalsplit_queue.sv -----
`timescale 1ns / 1ps

module nalsplit_queue import nalsplit_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  nalsplit_evt_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output nalsplit_evt_t pop_data
);

    nalsplit_evt_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg;
    logic [QCNT_WIDTH-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = count_reg == QCNT_WIDTH'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_WIDTH'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_WIDTH'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_WIDTH'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/nalsplit_back.sv -----
`timescale 1ns / 1ps

module nalsplit_back import nalsplit_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          evt_valid,
    input  nalsplit_evt_t evt,
    output logic          evt_pop,
    output logic          out_valid,
    output nalsplit_out_t out_data,
    input  logic          out_ready
);

    logic                 inside_reg;
    logic                 inside_next;
    logic [LEN_WIDTH-1:0] nal_start_reg;
    logic [LEN_WIDTH-1:0] nal_start_next;
    logic [7:0]           header_reg;
    logic [7:0]           header_next;
    logic                 key_seen_reg;
    logic                 key_seen_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    nalsplit_out_t        out_data_reg;
    nalsplit_out_t        out_data_next;

    logic                 closing;
    logic [LEN_WIDTH:0]   diff;
    logic [LEN_WIDTH-1:0] len;
    logic [7:0]           hdr_now;
    logic                 emit;
    logic                 key_now;

    assign evt_pop   = evt_valid && !(out_valid_reg && !out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign hdr_now = (inside_reg && (evt.pos == nal_start_reg)) ? evt.data_byte : header_reg;
    assign closing = inside_reg && (evt.start || evt.au_last);
    assign diff    = (evt.end_pos > {1'b0, nal_start_reg})
                     ? evt.end_pos - {1'b0, nal_start_reg} : '0;
    assign len     = diff[LEN_WIDTH] ? POS_MAX : diff[LEN_WIDTH-1:0];
    assign emit    = closing && (len >= LEN_WIDTH'(MIN_NAL_LEN));
    assign key_now = key_seen_reg || (emit && is_key_header(hdr_now));

    always_comb begin
        inside_next    = inside_reg;
        nal_start_next = nal_start_reg;
        header_next    = header_reg;
        key_seen_next  = key_seen_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (evt_pop) begin
            out_valid_next = emit || evt.au_last;
            out_data_next  = '0;
            if (emit) begin
                out_data_next.nal_valid  = 1'b1;
                out_data_next.nal_offset = nal_start_reg;
                out_data_next.nal_length = len;
                out_data_next.nal_header = hdr_now;
                out_data_next.type_h264  = h264_type(hdr_now);
                out_data_next.type_h265  = h265_type(hdr_now);
            end
            if (evt.au_last) begin
                out_data_next.au_end      = 1'b1;
                out_data_next.au_keyframe = key_now && evt.long_au;
                inside_next    = 1'b0;
                nal_start_next = '0;
                header_next    = '0;
                key_seen_next  = 1'b0;
            end else begin
                header_next   = hdr_now;
                key_seen_next = key_now;
                if (evt.start) begin
                    inside_next    = 1'b1;
                    nal_start_next = evt.pos_inc;
                end else if (closing) begin
                    inside_next = 1'b0;
                end
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg    <= 1'b0;
            nal_start_reg <= '0;
            header_reg    <= '0;
            key_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            inside_reg    <= inside_next;
            nal_start_reg <= nal_start_next;
            header_reg    <= header_next;
            key_seen_reg  <= key_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
